// ===== rtl/triangle_tangent_space_assert.svh =====
// Assertion macros for the tangent space block.
`ifndef TRIANGLE_TANGENT_SPACE_ASSERT_SVH
`define TRIANGLE_TANGENT_SPACE_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define TTS_ASSERT_NOW(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("tangent space check failed");
// next-cycle implication
`define TTS_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("tangent space check failed");
`else
`define TTS_ASSERT_NOW(label, pre, post)
`define TTS_ASSERT_NEXT(label, pre, post)
`endif
`endif

// ===== rtl/tts_pkg.sv =====
package tts_pkg;

   // input vertex
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] tex_u;
      logic signed [31:0] tex_v;
      logic               mesh_end;
   } req_type;

   // per-face result
   typedef struct packed {
      logic signed [15:0] tangent_x;
      logic signed [15:0] tangent_y;
      logic signed [15:0] tangent_z;
      logic signed [15:0] binormal_x;
      logic signed [15:0] binormal_y;
      logic signed [15:0] binormal_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               degenerate;
   } rsp_type;

   // output fraction bits; the result fields are Q1.14
   localparam int OUT_FRAC_BITS = 14;

   localparam int WIDE_W    = 67;
   localparam int NORM_BITS = 30;
   localparam int SQRT_STEPS = 31;

   // multiply step numbers: face products, then the cross product
   localparam logic [4:0] PROD_LAST  = 5'd14;
   localparam logic [4:0] CROSS_LAST = 5'd20;
   localparam logic [4:0] CROSS_FIRST = 5'd14;

   localparam logic [1:0] PHASE_THIRD = 2'd2;

   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic signed [32:0]       op_type;

   typedef enum logic [2:0] {
      TS_IDLE,
      TS_PROD,
      TS_NORM_T,
      TS_NORM_B,
      TS_CROSS,
      TS_NORM_N,
      TS_FINISH
   } top_state_type;

   typedef enum logic [2:0] {
      NS_IDLE,
      NS_SHIFT,
      NS_SQUARE,
      NS_SQRT,
      NS_LOAD,
      NS_DIV,
      NS_DONE
   } norm_state_type;

endpackage

// ===== rtl/tts_mul.sv =====
// Shared signed multiplier with registered product.
module tts_mul (
   input  logic             clock,
   input  tts_pkg::op_type  op_a,
   input  tts_pkg::op_type  op_b,
   output tts_pkg::wide_type prod
);

   logic signed [65:0] prod_in;
   tts_pkg::wide_type  prod_ff;

   assign prod_in = op_a * op_b;

   always_ff @(posedge clock) begin
      prod_ff <= {prod_in[65], prod_in};
   end

   assign prod = prod_ff;

endmodule

// ===== rtl/tts_norm.sv =====
// Iterative vector normalizer: scale, sum of squares, square root, divides.
module tts_norm #(
   parameter int OUT_FRAC_BITS = 14
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic                          flip,
   input  tts_pkg::wide_type             vec [3],
   output logic                          done,
   output logic                          zero,
   output logic signed [OUT_FRAC_BITS+1:0] q [3]
);

   localparam int DSTEPS = OUT_FRAC_BITS + 1;
   localparam int QW     = OUT_FRAC_BITS + 2;
   localparam int NUM_W  = tts_pkg::NORM_BITS + OUT_FRAC_BITS + 1;
   localparam int MAXC   = (DSTEPS > tts_pkg::SQRT_STEPS) ? DSTEPS : tts_pkg::SQRT_STEPS;
   localparam int CNT_W  = $clog2(MAXC + 1);
   localparam int W      = tts_pkg::WIDE_W;

   tts_pkg::norm_state_type state_ff, state_in;

   logic [W-1:0]        m_ff [3];
   logic                neg_ff [3];
   logic [59:0]         sq_ff;
   logic [61:0]         sum_ff;
   logic [61:0]         r_ff;
   logic [61:0]         bit_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic [1:0]          comp_ff;
   logic [NUM_W-1:0]    num_ff;
   logic [31:0]         rem_ff;
   logic [DSTEPS-1:0]   quo_ff;
   logic signed [QW-1:0] q_ff [3];
   logic                zero_ff;

   logic [W-1:0]        or_w;
   logic [29:0]         sq_src;
   logic [61:0]         sqrt_try;
   logic                sqrt_ge;
   logic [30:0]         len;
   logic [NUM_W-1:0]    num_load;
   logic [32:0]         trial;
   logic                div_ge;
   logic [DSTEPS-1:0]   quo_in;
   logic [DSTEPS-1:0]   quo_mag;
   logic                sqrt_last, div_last, sq_last;

   // datapath helpers
   always_comb begin
      or_w     = m_ff[0] | m_ff[1] | m_ff[2];
      sq_src   = (cnt_ff[1:0] == 2'd3) ? 30'd0 : m_ff[cnt_ff[1:0]][29:0];
      sqrt_try = r_ff + bit_ff;
      sqrt_ge  = sum_ff >= sqrt_try;
      len      = r_ff[30:0];
      num_load = (NUM_W'(m_ff[comp_ff][29:0]) << OUT_FRAC_BITS) + NUM_W'(len >> 1);
      trial    = {rem_ff, num_ff[DSTEPS-1]};
      div_ge   = trial >= 33'(len);
      quo_in   = {quo_ff[DSTEPS-2:0], div_ge};
      quo_mag  = (quo_in > (DSTEPS'(1) << OUT_FRAC_BITS)) ?
                 (DSTEPS'(1) << OUT_FRAC_BITS) : quo_in;
      sq_last   = cnt_ff == CNT_W'(3);
      sqrt_last = cnt_ff == CNT_W'(tts_pkg::SQRT_STEPS - 1);
      div_last  = cnt_ff == CNT_W'(DSTEPS - 1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tts_pkg::NS_IDLE:   if (start) state_in = tts_pkg::NS_SHIFT;
         tts_pkg::NS_SHIFT: begin
            if (or_w == '0) state_in = tts_pkg::NS_DONE;
            else if (or_w[W-1:30] == '0 && or_w[29]) state_in = tts_pkg::NS_SQUARE;
         end
         tts_pkg::NS_SQUARE: if (sq_last) state_in = tts_pkg::NS_SQRT;
         tts_pkg::NS_SQRT:   if (sqrt_last) state_in = tts_pkg::NS_LOAD;
         tts_pkg::NS_LOAD:   state_in = tts_pkg::NS_DIV;
         tts_pkg::NS_DIV: begin
            if (div_last) state_in = (comp_ff == 2'd2) ? tts_pkg::NS_DONE : tts_pkg::NS_LOAD;
         end
         tts_pkg::NS_DONE:   state_in = tts_pkg::NS_IDLE;
         default:            state_in = tts_pkg::NS_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      done = state_ff == tts_pkg::NS_DONE;
      zero = zero_ff;
      q    = q_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= tts_pkg::NS_IDLE;
      else       state_ff <= state_in;
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         tts_pkg::NS_IDLE: begin
            if (start) begin
               for (int i = 0; i < 3; i++) begin
                  m_ff[i]   <= vec[i][W-1] ? W'(-vec[i]) : W'(vec[i]);
                  neg_ff[i] <= vec[i][W-1] ^ flip;
               end
               zero_ff <= 1'b0;
            end
         end
         tts_pkg::NS_SHIFT: begin
            // bring the top set bit to bit 29; right shifts truncate
            if (or_w == '0) begin
               zero_ff <= 1'b1;
            end else if (or_w[W-1:38] != '0) begin
               for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 8;
            end else if (or_w[W-1:30] != '0) begin
               for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] >> 1;
            end else if (or_w[29:22] == '0) begin
               for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 8;
            end else if (!or_w[29]) begin
               for (int i = 0; i < 3; i++) m_ff[i] <= m_ff[i] << 1;
            end else begin
               cnt_ff <= '0;
               sum_ff <= '0;
            end
         end
         tts_pkg::NS_SQUARE: begin
            // square one component per cycle, add the previous one
            sq_ff <= sq_src * sq_src;
            if (cnt_ff != '0) sum_ff <= sum_ff + 62'(sq_ff);
            cnt_ff <= cnt_ff + 1'b1;
            if (sq_last) begin
               cnt_ff <= '0;
               r_ff   <= '0;
               bit_ff <= 62'(1) << 60;
            end
         end
         tts_pkg::NS_SQRT: begin
            // one result bit per cycle
            if (sqrt_ge) begin
               sum_ff <= sum_ff - sqrt_try;
               r_ff   <= (r_ff >> 1) + bit_ff;
            end else begin
               r_ff <= r_ff >> 1;
            end
            bit_ff  <= bit_ff >> 2;
            cnt_ff  <= cnt_ff + 1'b1;
            comp_ff <= 2'd0;
         end
         tts_pkg::NS_LOAD: begin
            num_ff <= num_load;
            rem_ff <= 32'(num_load >> DSTEPS);
            quo_ff <= '0;
            cnt_ff <= '0;
         end
         tts_pkg::NS_DIV: begin
            // restoring divide, one quotient bit per cycle
            rem_ff <= div_ge ? 32'(trial - 33'(len)) : trial[31:0];
            num_ff <= num_ff << 1;
            quo_ff <= quo_in;
            cnt_ff <= cnt_ff + 1'b1;
            if (div_last) begin
               q_ff[comp_ff] <= neg_ff[comp_ff] ? -QW'(quo_mag) : QW'(quo_mag);
               comp_ff <= comp_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ===== rtl/triangle_tangent_space.sv =====
// Vertices 1 and 2 of a face are each registered when their transfer is accepted.
// The third vertex starts the face: the face products on the one shared multiplier,
// normalizer passes for the tangent and the binormal, the cross product, and a third
// normalizer pass for the normal; the normalizer uses a bit-serial root and divide.
// One face in flight; the next face's first two vertices are taken while its result waits.
// Synchronous active-high reset clears the face phase, sequencer and result valid.
`include "triangle_tangent_space_assert.svh"
module triangle_tangent_space (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tts_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tts_pkg::rsp_type rsp_data
);

   localparam int QW = tts_pkg::OUT_FRAC_BITS + 2;

   tts_pkg::top_state_type state_ff, state_in;

   logic [1:0]          phase_ff;
   logic [1:0]          phase;
   logic signed [31:0]  v1_ff [5];
   logic signed [31:0]  v2_ff [5];
   logic signed [31:0]  v3_ff [5];
   logic signed [31:0]  vin [5];
   logic [4:0]          k_ff;
   logic [4:0]          k_prev;
   tts_pkg::wide_type   acc_ff;
   tts_pkg::wide_type   res_ff [10];
   logic signed [QW-1:0] tq_ff [3];
   logic signed [QW-1:0] bq_ff [3];
   logic                degen_ff;
   logic                kicked_ff;
   logic                rsp_valid_ff;
   tts_pkg::rsp_type    rsp_ff;

   logic                req_xfer, rsp_xfer;
   tts_pkg::op_type     op_a, op_b;
   tts_pkg::wide_type   prod;
   logic signed [32:0]  e1 [3];
   logic signed [32:0]  e2 [3];
   logic signed [32:0]  du1, dv1, du2, dv2;
   logic                acc_step;
   logic                norm_state;
   logic                norm_start, norm_flip, norm_done, norm_zero;
   tts_pkg::wide_type   norm_vec [3];
   logic signed [QW-1:0] norm_q [3];
   logic                det_neg;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid_ff && rsp_ready;
   assign phase    = (phase_ff == 2'd3) ? 2'd0 : phase_ff;
   assign det_neg  = res_ff[0][tts_pkg::WIDE_W-1];
   assign k_prev   = k_ff - 5'd1;

   assign vin[0] = req_data.pos_x;
   assign vin[1] = req_data.pos_y;
   assign vin[2] = req_data.pos_z;
   assign vin[3] = req_data.tex_u;
   assign vin[4] = req_data.tex_v;

   // edge vectors and texture deltas
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1[i] = 33'(v2_ff[i]) - 33'(v1_ff[i]);
         e2[i] = 33'(v3_ff[i]) - 33'(v1_ff[i]);
      end
      du1 = 33'(v2_ff[3]) - 33'(v1_ff[3]);
      dv1 = 33'(v2_ff[4]) - 33'(v1_ff[4]);
      du2 = 33'(v3_ff[3]) - 33'(v1_ff[3]);
      dv2 = 33'(v3_ff[4]) - 33'(v1_ff[4]);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tts_pkg::TS_IDLE:   if (req_xfer && phase == tts_pkg::PHASE_THIRD) state_in = tts_pkg::TS_PROD;
         tts_pkg::TS_PROD: begin
            if (k_ff == tts_pkg::PROD_LAST)
               state_in = (res_ff[0] == '0) ? tts_pkg::TS_FINISH : tts_pkg::TS_NORM_T;
         end
         tts_pkg::TS_NORM_T: if (norm_done) state_in = norm_zero ? tts_pkg::TS_FINISH : tts_pkg::TS_NORM_B;
         tts_pkg::TS_NORM_B: if (norm_done) state_in = norm_zero ? tts_pkg::TS_FINISH : tts_pkg::TS_CROSS;
         tts_pkg::TS_CROSS:  if (k_ff == tts_pkg::CROSS_LAST) state_in = tts_pkg::TS_NORM_N;
         tts_pkg::TS_NORM_N: if (norm_done) state_in = tts_pkg::TS_FINISH;
         tts_pkg::TS_FINISH: state_in = tts_pkg::TS_IDLE;
         default:            state_in = tts_pkg::TS_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready  = (state_ff == tts_pkg::TS_IDLE) &&
                   (!rsp_valid_ff || phase != tts_pkg::PHASE_THIRD);
      norm_state = (state_ff == tts_pkg::TS_NORM_T) || (state_ff == tts_pkg::TS_NORM_B) ||
                   (state_ff == tts_pkg::TS_NORM_N);
      norm_start = norm_state && !kicked_ff;
      acc_step   = ((state_ff == tts_pkg::TS_PROD) && (k_ff != 5'd0)) ||
                   ((state_ff == tts_pkg::TS_CROSS) && (k_ff != tts_pkg::CROSS_FIRST));
      norm_flip  = det_neg && (state_ff != tts_pkg::TS_NORM_N);
      for (int i = 0; i < 3; i++) begin
         if (state_ff == tts_pkg::TS_NORM_T)      norm_vec[i] = res_ff[1 + i];
         else if (state_ff == tts_pkg::TS_NORM_B) norm_vec[i] = res_ff[4 + i];
         else                                     norm_vec[i] = res_ff[7 + i];
      end
      // operand pairs; each even step's product is loaded, the odd step's product is subtracted from it
      op_a = '0;
      op_b = '0;
      case (k_ff)
         5'd0:  begin op_a = du1; op_b = dv2; end
         5'd1:  begin op_a = du2; op_b = dv1; end
         5'd2:  begin op_a = dv2; op_b = e1[0]; end
         5'd3:  begin op_a = dv1; op_b = e2[0]; end
         5'd4:  begin op_a = dv2; op_b = e1[1]; end
         5'd5:  begin op_a = dv1; op_b = e2[1]; end
         5'd6:  begin op_a = dv2; op_b = e1[2]; end
         5'd7:  begin op_a = dv1; op_b = e2[2]; end
         5'd8:  begin op_a = du1; op_b = e2[0]; end
         5'd9:  begin op_a = du2; op_b = e1[0]; end
         5'd10: begin op_a = du1; op_b = e2[1]; end
         5'd11: begin op_a = du2; op_b = e1[1]; end
         5'd12: begin op_a = du1; op_b = e2[2]; end
         5'd13: begin op_a = du2; op_b = e1[2]; end
         5'd14: begin op_a = 33'(tq_ff[1]); op_b = 33'(bq_ff[2]); end
         5'd15: begin op_a = 33'(tq_ff[2]); op_b = 33'(bq_ff[1]); end
         5'd16: begin op_a = 33'(tq_ff[2]); op_b = 33'(bq_ff[0]); end
         5'd17: begin op_a = 33'(tq_ff[0]); op_b = 33'(bq_ff[2]); end
         5'd18: begin op_a = 33'(tq_ff[0]); op_b = 33'(bq_ff[1]); end
         5'd19: begin op_a = 33'(tq_ff[1]); op_b = 33'(bq_ff[0]); end
         default: begin
         end
      endcase
   end

   tts_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   tts_norm #(
      .OUT_FRAC_BITS (tts_pkg::OUT_FRAC_BITS)
   ) u_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .flip  (norm_flip),
      .vec   (norm_vec),
      .done  (norm_done),
      .zero  (norm_zero),
      .q     (norm_q)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tts_pkg::TS_IDLE;
         phase_ff     <= 2'd0;
         kicked_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (req_xfer) begin
            if (phase == tts_pkg::PHASE_THIRD || req_data.mesh_end) phase_ff <= 2'd0;
            else                                                 phase_ff <= phase + 2'd1;
         end
         if (norm_done)       kicked_ff <= 1'b0;
         else if (norm_start) kicked_ff <= 1'b1;
         if (state_ff == tts_pkg::TS_FINISH) rsp_valid_ff <= 1'b1;
         else if (rsp_xfer)                  rsp_valid_ff <= 1'b0;
      end
   end

   // vertex hold, accumulation and result registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         for (int i = 0; i < 5; i++) begin
            if (phase == 2'd0 && !req_data.mesh_end) v1_ff[i] <= vin[i];
            if (phase == 2'd1 && !req_data.mesh_end) v2_ff[i] <= vin[i];
            if (phase == tts_pkg::PHASE_THIRD)       v3_ff[i] <= vin[i];
         end
      end

      if (state_ff == tts_pkg::TS_PROD || state_ff == tts_pkg::TS_CROSS) k_ff <= k_ff + 5'd1;
      else if (state_ff == tts_pkg::TS_NORM_B)                            k_ff <= tts_pkg::CROSS_FIRST;
      else                                                                k_ff <= 5'd0;

      if (acc_step) begin
         if (!k_prev[0]) acc_ff <= prod;
         else            res_ff[k_prev[4:1]] <= acc_ff - prod;
      end

      if (state_ff == tts_pkg::TS_IDLE) degen_ff <= 1'b0;
      else if (state_ff == tts_pkg::TS_PROD && k_ff == tts_pkg::PROD_LAST && res_ff[0] == '0)
         degen_ff <= 1'b1;
      else if (norm_state && norm_done && norm_zero)
         degen_ff <= 1'b1;

      if (state_ff == tts_pkg::TS_NORM_T && norm_done) tq_ff <= norm_q;
      if (state_ff == tts_pkg::TS_NORM_B && norm_done) bq_ff <= norm_q;

      if (state_ff == tts_pkg::TS_FINISH) begin
         rsp_ff.tangent_x  <= degen_ff ? 16'sd0 : 16'(tq_ff[0]);
         rsp_ff.tangent_y  <= degen_ff ? 16'sd0 : 16'(tq_ff[1]);
         rsp_ff.tangent_z  <= degen_ff ? 16'sd0 : 16'(tq_ff[2]);
         rsp_ff.binormal_x <= degen_ff ? 16'sd0 : 16'(bq_ff[0]);
         rsp_ff.binormal_y <= degen_ff ? 16'sd0 : 16'(bq_ff[1]);
         rsp_ff.binormal_z <= degen_ff ? 16'sd0 : 16'(bq_ff[2]);
         rsp_ff.normal_x   <= degen_ff ? 16'sd0 : 16'(norm_q[0]);
         rsp_ff.normal_y   <= degen_ff ? 16'sd0 : 16'(norm_q[1]);
         rsp_ff.normal_z   <= degen_ff ? 16'sd0 : 16'(norm_q[2]);
         rsp_ff.degenerate <= degen_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `TTS_ASSERT_NEXT(a_third_starts, req_xfer && phase == tts_pkg::PHASE_THIRD, state_ff == tts_pkg::TS_PROD)
   `TTS_ASSERT_NOW(a_done_in_norm, norm_done, norm_state)
   `TTS_ASSERT_NOW(a_degen_zero, rsp_valid_ff && rsp_ff.degenerate, rsp_ff.tangent_x == 16'sd0 && rsp_ff.normal_z == 16'sd0)
   `TTS_ASSERT_NEXT(a_finish_valid, state_ff == tts_pkg::TS_FINISH, rsp_valid_ff)

endmodule
